[rtl/cubic_curve_point_eval_assert.svh]
// Assertion macros shared by the cubic curve point evaluator.
`ifndef CUBIC_CURVE_POINT_EVAL_ASSERT_SVH
`define CUBIC_CURVE_POINT_EVAL_ASSERT_SVH

// Same-cycle implication, off during reset.
`define CCPE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define CCPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/ccpe_pkg.sv]
// Shared constants, types and helpers of the cubic curve point evaluator.
`default_nettype none

package ccpe_pkg;

   // Field widths
   localparam int COORD_BITS = 16;
   localparam int T_BITS     = 16;

   // Internal fixed-point formats: t in Q0.20, weights in Q1.26
   localparam int TQ_BITS   = 20;
   localparam int WF_BITS   = 26;
   localparam int W_BITS    = WF_BITS + 1;
   localparam int RAW_SHIFT = 3 * TQ_BITS - WF_BITS;

   localparam logic [TQ_BITS:0]  TQ_ONE = {1'b1, {TQ_BITS{1'b0}}};
   localparam logic [W_BITS-1:0] WF_ONE = {1'b1, {WF_BITS{1'b0}}};

   // Pipeline stages, in order from the input register to the output register
   localparam int ST_IN    = 0;   // t quantized, 1-t formed
   localparam int ST_SQR   = 1;   // t^2, (1-t)^2
   localparam int ST_PART  = 2;   // split partial products of the cubes
   localparam int ST_CUBE  = 3;   // t^3, (1-t)^3, t(1-t)^2
   localparam int ST_SUM   = 4;   // raw partial sums of the weights
   localparam int ST_RND   = 5;   // rounded partial sums, scaled by 2^-34
   localparam int ST_DIV   = 6;   // reciprocal products for the divide by 3
   localparam int ST_WGT   = 7;   // final Q1.26 weights
   localparam int ST_PROD  = 8;   // coordinate times weight
   localparam int ST_PAIR  = 9;   // pair sums
   localparam int ST_OUT   = 10;  // rounded point, output register
   localparam int NUM_STAGES = ST_OUT + 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [W_BITS-1:0]            weight_type;
   typedef logic [NUM_STAGES-1:0]        stage_en_type;

   typedef enum logic {
      KIND_BEZIER  = 1'b0,
      KIND_BSPLINE = 1'b1
   } kind_type;

   // Bring t to Q0.20: shift up for narrow t, drop low bits for wide t
   function automatic logic [TQ_BITS-1:0] to_tq(input logic [T_BITS-1:0] t);
      logic [T_BITS+TQ_BITS-1:0] scaled;
      scaled = {t, {TQ_BITS{1'b0}}};
      return scaled[T_BITS+TQ_BITS-1 -: TQ_BITS];
   endfunction

endpackage

`default_nettype wire

[rtl/ccpe_weights.sv]
// Basis weight pipeline: four Q1.26 weights from t and the curve kind.
`default_nettype none

module ccpe_weights
   import ccpe_pkg::*;
(
   input  wire logic               clock,
   input  wire stage_en_type       stage_en,
   input  wire logic [TQ_BITS-1:0] tq,
   input  wire logic [TQ_BITS:0]   uq,
   input  wire kind_type           kind,
   output weight_type              w [4]
);

   localparam int T2W = 2 * TQ_BITS;          // t^2
   localparam int U2W = 2 * TQ_BITS + 1;      // (1-t)^2
   localparam int PW  = 2 * TQ_BITS + 2;      // split partial products
   localparam int CW  = 3 * TQ_BITS + 4;      // cubes and raw partial sums
   localparam int QW  = CW - RAW_SHIFT;       // rounded partial sums
   localparam int DIV3_SHIFT = QW;
   localparam int MW  = 2 * (QW - 1);         // reciprocal product
   localparam logic [QW-2:0] DIV3_MULT =
      (QW-1)'(((64'd1 << DIV3_SHIFT) + 64'd2) / 64'd3);
   localparam logic [CW-1:0] ONE3 = CW'(1) << (3 * TQ_BITS);

   // Stage ST_SQR
   logic [TQ_BITS-1:0] tq2_ff;
   logic [TQ_BITS:0]   uq2_ff;
   logic [T2W-1:0]     t2_ff;
   logic [U2W-1:0]     u2_ff;
   kind_type           kind2_ff;

   // Stage ST_PART
   logic [PW-1:0]      t3h_ff, t3l_ff, u3h_ff, u3l_ff, tuh_ff, tul_ff;
   logic [T2W-1:0]     t2p_ff;
   kind_type           kind3_ff;

   // Stage ST_CUBE
   logic [CW-1:0]      t3_ff, u3_ff, tu2_ff;
   logic [T2W-1:0]     t2c_ff;
   kind_type           kind4_ff;

   // Stage ST_SUM
   logic [CW-1:0]      s_in [3];
   logic [CW-1:0]      s_ff [3];
   logic [CW-1:0]      t2x;
   kind_type           kind5_ff;

   // Stage ST_RND
   logic [CW-1:0]      biased [3];
   logic [QW-1:0]      q_in [3];
   logic [QW-1:0]      q_ff [3];
   kind_type           kind6_ff;

   // Stage ST_DIV
   logic [MW-1:0]      m_ff [3];
   logic [QW-1:0]      qd_ff [3];
   kind_type           kind7_ff;

   // Stage ST_WGT
   weight_type         r [3];
   weight_type         w_in [4];
   weight_type         w_ff [4];

   // Square t and 1-t
   always_ff @(posedge clock) begin
      if (stage_en[ST_SQR]) begin
         t2_ff    <= T2W'(tq) * T2W'(tq);
         u2_ff    <= U2W'(uq) * U2W'(uq);
         tq2_ff   <= tq;
         uq2_ff   <= uq;
         kind2_ff <= kind;
      end
   end

   // Split the squares in halves and multiply each half by t or 1-t
   always_ff @(posedge clock) begin
      if (stage_en[ST_PART]) begin
         t3h_ff   <= PW'(t2_ff[T2W-1:TQ_BITS]) * PW'(tq2_ff);
         t3l_ff   <= PW'(t2_ff[TQ_BITS-1:0])   * PW'(tq2_ff);
         u3h_ff   <= PW'(u2_ff[U2W-1:TQ_BITS]) * PW'(uq2_ff);
         u3l_ff   <= PW'(u2_ff[TQ_BITS-1:0])   * PW'(uq2_ff);
         tuh_ff   <= PW'(u2_ff[U2W-1:TQ_BITS]) * PW'(tq2_ff);
         tul_ff   <= PW'(u2_ff[TQ_BITS-1:0])   * PW'(tq2_ff);
         t2p_ff   <= t2_ff;
         kind3_ff <= kind2_ff;
      end
   end

   // Recombine the halves into full cubes
   always_ff @(posedge clock) begin
      if (stage_en[ST_CUBE]) begin
         t3_ff    <= (CW'(t3h_ff) << TQ_BITS) + CW'(t3l_ff);
         u3_ff    <= (CW'(u3h_ff) << TQ_BITS) + CW'(u3l_ff);
         tu2_ff   <= (CW'(tuh_ff) << TQ_BITS) + CW'(tul_ff);
         t2c_ff   <= t2p_ff;
         kind4_ff <= kind3_ff;
      end
   end

   // Form the raw partial sums of the weights, scaled by 2^60
   always_comb begin
      t2x     = CW'(t2c_ff) << TQ_BITS;
      s_in[0] = u3_ff;
      if (kind4_ff == KIND_BSPLINE) begin
         s_in[1] = u3_ff + (ONE3 << 2) + (t3_ff << 1) + t3_ff - ((t2x << 2) + (t2x << 1));
         s_in[2] = (ONE3 << 2) + (ONE3 << 1) - t3_ff;
      end else begin
         s_in[1] = u3_ff + (tu2_ff << 1) + tu2_ff;
         s_in[2] = ONE3 - t3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_SUM]) begin
         s_ff     <= s_in;
         kind5_ff <= kind4_ff;
      end
   end

   // Round half up in units of 2^34; for the B-spline the remaining divide by 6 follows
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (kind5_ff == KIND_BSPLINE) begin
            biased[k] = s_ff[k] + (CW'(3) << RAW_SHIFT);
         end else begin
            biased[k] = s_ff[k] + (CW'(1) << (RAW_SHIFT - 1));
         end
         q_in[k] = biased[k][CW-1:RAW_SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_RND]) begin
         q_ff     <= q_in;
         kind6_ff <= kind5_ff;
      end
   end

   // Divide by 6 as halve, then multiply by the rounded-up reciprocal of 3
   always_ff @(posedge clock) begin
      if (stage_en[ST_DIV]) begin
         for (int k = 0; k < 3; k++) begin
            m_ff[k] <= MW'(q_ff[k][QW-1:1]) * MW'(DIV3_MULT);
         end
         qd_ff    <= q_ff;
         kind7_ff <= kind6_ff;
      end
   end

   // Select the rounded partial sums and take differences as weights
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (kind7_ff == KIND_BSPLINE) begin
            r[k] = m_ff[k][DIV3_SHIFT +: W_BITS];
         end else begin
            r[k] = qd_ff[k][W_BITS-1:0];
         end
      end
      w_in[0] = r[0];
      w_in[1] = r[1] - r[0];
      w_in[2] = r[2] - r[1];
      w_in[3] = WF_ONE - r[2];
   end

   always_ff @(posedge clock) begin
      if (stage_en[ST_WGT]) begin
         w_ff <= w_in;
      end
   end

   assign w = w_ff;

endmodule

`default_nettype wire

[rtl/ccpe_blend.sv]
// Blend pipeline for one axis: weighted sum of four coordinates, rounded.
`default_nettype none

module ccpe_blend
   import ccpe_pkg::*;
(
   input  wire logic         clock,
   input  wire stage_en_type stage_en,
   input  wire coord_type    ctrl [4],
   input  wire weight_type   w [4],
   output coord_type         point
);

   localparam int PRW = COORD_BITS + W_BITS + 1;
   localparam logic signed [PRW+1:0] RND = (PRW+2)'(1) << (WF_BITS - 1);

   logic signed [PRW-1:0] prod_ff [4];
   logic signed [PRW:0]   pair_ff [2];
   logic signed [PRW+1:0] acc;
   coord_type             point_ff;

   // Multiply each coordinate by its weight
   always_ff @(posedge clock) begin
      if (stage_en[ST_PROD]) begin
         for (int k = 0; k < 4; k++) begin
            prod_ff[k] <= PRW'(ctrl[k]) * PRW'(signed'({1'b0, w[k]}));
         end
      end
   end

   // Add the products in pairs
   always_ff @(posedge clock) begin
      if (stage_en[ST_PAIR]) begin
         pair_ff[0] <= (PRW+1)'(prod_ff[0]) + (PRW+1)'(prod_ff[1]);
         pair_ff[1] <= (PRW+1)'(prod_ff[2]) + (PRW+1)'(prod_ff[3]);
      end
   end

   // Final sum, round half toward +infinity, drop the weight fraction
   assign acc = (PRW+2)'(pair_ff[0]) + (PRW+2)'(pair_ff[1]) + RND;

   always_ff @(posedge clock) begin
      if (stage_en[ST_OUT]) begin
         point_ff <= acc[WF_BITS +: COORD_BITS];
      end
   end

   assign point = point_ff;

endmodule

`default_nettype wire

[rtl/cubic_curve_point_eval.sv]
// Cubic Bezier / uniform cubic B-spline point evaluator, top level.
// A word accepted at the input moves from the input register on to the output
// register (11 register stages) before it shows on rsp_valid.
// Throughput: one word per cycle; each stage holds only while the stage after
// it is full and stalled, so bubbles close up under backpressure.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none
`include "cubic_curve_point_eval_assert.svh"

module cubic_curve_point_eval
   import ccpe_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_kind,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl0_x,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl0_y,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl1_x,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl1_y,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl2_x,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl2_y,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl3_x,
   input  wire logic signed [COORD_BITS-1:0] req_ctrl3_y,
   input  wire logic [T_BITS-1:0]        req_t_frac,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic signed [COORD_BITS-1:0]  rsp_point_x,
   output logic signed [COORD_BITS-1:0]  rsp_point_y
);

   stage_en_type       stage_en;
   stage_en_type       valid_in;
   stage_en_type       valid_ff;
   logic               req_accept;
   logic               rsp_accept;

   logic [TQ_BITS-1:0] tq_ff;
   logic [TQ_BITS:0]   uq_ff;
   kind_type           kind_ff;

   coord_type          cx_ff [ST_WGT+1][4];
   coord_type          cy_ff [ST_WGT+1][4];

   weight_type         w [4];
   logic [W_BITS+1:0]  wsum;

   // Advance a stage when it is empty or the stage after it advances
   always_comb begin
      stage_en[ST_OUT] = !valid_ff[ST_OUT] || rsp_ready;
      for (int s = ST_OUT - 1; s >= 0; s--) begin
         stage_en[s] = !valid_ff[s] || stage_en[s+1];
      end
   end

   assign req_ready  = stage_en[ST_IN];
   assign req_accept = req_valid && req_ready;
   assign rsp_valid  = valid_ff[ST_OUT];
   assign rsp_accept = rsp_valid && rsp_ready;

   // Move valid bits along with the data
   always_comb begin
      valid_in[ST_IN] = req_valid;
      for (int s = 1; s < NUM_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (stage_en[s]) begin
               valid_ff[s] <= valid_in[s];
            end
         end
      end
   end

   // Capture the input word; quantize t and form 1-t
   always_ff @(posedge clock) begin
      if (stage_en[ST_IN]) begin
         tq_ff       <= to_tq(req_t_frac);
         uq_ff       <= TQ_ONE - (TQ_BITS+1)'(to_tq(req_t_frac));
         kind_ff     <= kind_type'(req_kind);
      end
   end

   // Capture the control points and delay them until their weights are ready
   always_ff @(posedge clock) begin
      if (stage_en[ST_IN]) begin
         cx_ff[0][0] <= req_ctrl0_x;
         cx_ff[0][1] <= req_ctrl1_x;
         cx_ff[0][2] <= req_ctrl2_x;
         cx_ff[0][3] <= req_ctrl3_x;
         cy_ff[0][0] <= req_ctrl0_y;
         cy_ff[0][1] <= req_ctrl1_y;
         cy_ff[0][2] <= req_ctrl2_y;
         cy_ff[0][3] <= req_ctrl3_y;
      end
      for (int s = 1; s <= ST_WGT; s++) begin
         if (stage_en[s]) begin
            cx_ff[s] <= cx_ff[s-1];
            cy_ff[s] <= cy_ff[s-1];
         end
      end
   end

   ccpe_weights u_weights (
      .clock    (clock),
      .stage_en (stage_en),
      .tq       (tq_ff),
      .uq       (uq_ff),
      .kind     (kind_ff),
      .w        (w)
   );

   ccpe_blend u_blend_x (
      .clock    (clock),
      .stage_en (stage_en),
      .ctrl     (cx_ff[ST_WGT]),
      .w        (w),
      .point    (rsp_point_x)
   );

   ccpe_blend u_blend_y (
      .clock    (clock),
      .stage_en (stage_en),
      .ctrl     (cy_ff[ST_WGT]),
      .w        (w),
      .point    (rsp_point_y)
   );

   assign wsum = (W_BITS+2)'(w[0]) + (W_BITS+2)'(w[1])
               + (W_BITS+2)'(w[2]) + (W_BITS+2)'(w[3]);

   // Weights of a live word form a partition of one
   `CCPE_ASSERT_NOW(a_weight_sum, clock, reset, valid_ff[ST_WGT], wsum == (W_BITS+2)'(WF_ONE), "weights do not sum to one")

   // Never take a word while every stage is full and the output stalls
   `CCPE_ASSERT_NOW(a_full_stall, clock, reset, req_ready, rsp_ready || $countones(valid_ff) < NUM_STAGES, "input ready with pipeline full and stalled")

   // Words in flight change only by accepted input and output words
   `CCPE_ASSERT_NEXT(a_word_count, clock, reset, 1'b1, $countones(valid_ff) == $past($countones(valid_ff)) + int'($past(req_accept)) - int'($past(rsp_accept)), "word count in pipeline broken")

endmodule

`default_nettype wire
